FILE: hw/rtl/tkh_pkg.sv
// ============================================================================
// tkh_pkg
// Shared types and constants for the top-K min-heap keeper.
// ============================================================================
`default_nettype none

package tkh_pkg;

    localparam int VALUE_W = 31;
    localparam int KEEP_W  = 7;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DOWN,
        ST_PLACE,
        ST_DONE
    } tkh_state_t;

    typedef struct packed {
        logic               heap_full;
        logic [KEEP_W-1:0]  kept_count;
        logic [VALUE_W-1:0] smallest_kept;
    } tkh_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tkh_ram.sv
// ============================================================================
// tkh_ram
// Generic synchronous RAM with one write port and two registered read ports.
// ============================================================================
`default_nettype none

module tkh_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tkh_walker.sv
// ============================================================================
// tkh_walker
// Heap sequencer: appends and sifts up, replaces the root and sifts down,
// or drops it; a sift moves one heap level per cycle through the heap memory.
// ============================================================================
`default_nettype none

module tkh_walker #(
    parameter int HEAP_DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              keep_count_wr_en,
    input  wire logic [tkh_pkg::KEEP_W-1:0]        keep_count_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [tkh_pkg::VALUE_W-1:0]       in_value,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output tkh_pkg::tkh_result_t                   res,
    output logic                                   ram_wr_en,
    output logic [$clog2(HEAP_DEPTH)-1:0]          ram_wr_addr,
    output logic [tkh_pkg::VALUE_W-1:0]            ram_wr_data,
    output logic [$clog2(HEAP_DEPTH)-1:0]          ram_rd_addr_a,
    output logic [$clog2(HEAP_DEPTH)-1:0]          ram_rd_addr_b,
    input  wire logic [tkh_pkg::VALUE_W-1:0]       ram_rd_data_a,
    input  wire logic [tkh_pkg::VALUE_W-1:0]       ram_rd_data_b
);

    localparam int AW    = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int CW    = AW + 2;

    tkh_pkg::tkh_state_t state_reg, state_next;

    logic [AW-1:0]                  pos_reg, pos_next;
    logic [tkh_pkg::VALUE_W-1:0]    val_reg, val_next;
    logic [tkh_pkg::VALUE_W-1:0]    root_reg, root_next;
    logic                           rv_reg, rv_next;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic [tkh_pkg::KEEP_W-1:0]     keep_reg;

    logic [CNT_W-1:0]               lim;
    logic                           append;
    logic [CW-1:0]                  fill_ext;
    logic [AW-1:0]                  cur_par;
    logic [AW-1:0]                  up_src;
    logic [AW-1:0]                  up_par;
    logic [CW-1:0]                  cur_left;
    logic [CW-1:0]                  cur_right;
    logic                           pick_right;
    logic [tkh_pkg::VALUE_W-1:0]    pick_val;
    logic [AW-1:0]                  pick_pos;
    logic [AW-1:0]                  down_src;
    logic [CW-1:0]                  next_left;
    logic [CW-1:0]                  next_right;
    logic                           left_ok;
    logic                           right_ok;
    logic                           up_mode;

    // A limit of zero acts as one, and a limit past the storage is clipped.
    always_comb
    begin
        if (keep_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (32'(keep_reg) > 32'(HEAP_DEPTH))
        begin
            lim = CNT_W'(HEAP_DEPTH);
        end
        else
        begin
            lim = CNT_W'(keep_reg);
        end
    end

    assign append   = fill_reg < lim;
    assign fill_ext = CW'(fill_reg);

    assign cur_par = (pos_reg - AW'(1)) >> 1;
    assign up_src  = (state_reg == tkh_pkg::ST_IDLE) ? AW'(fill_reg) : cur_par;
    assign up_par  = (up_src - AW'(1)) >> 1;

    assign cur_left   = {1'b0, pos_reg, 1'b1};
    assign cur_right  = cur_left + CW'(1);
    assign pick_right = rv_reg && (ram_rd_data_b < ram_rd_data_a);
    assign pick_val   = pick_right ? ram_rd_data_b : ram_rd_data_a;
    assign pick_pos   = pick_right ? AW'(cur_right) : AW'(cur_left);

    assign down_src   = (state_reg == tkh_pkg::ST_IDLE) ? '0 : pick_pos;
    assign next_left  = {1'b0, down_src, 1'b1};
    assign next_right = next_left + CW'(1);
    assign left_ok    = next_left < fill_ext;
    assign right_ok   = next_right < fill_ext;

    assign up_mode       = (state_reg == tkh_pkg::ST_UP) ||
                           ((state_reg == tkh_pkg::ST_IDLE) && append);
    assign ram_rd_addr_a = up_mode ? up_par : AW'(next_left);
    assign ram_rd_addr_b = AW'(next_right);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rv_next     = rv_reg;
        fill_next   = fill_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = val_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            tkh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next = in_value;
                    if (append)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                        pos_next  = AW'(fill_reg);
                        state_next = (fill_reg == '0) ? tkh_pkg::ST_PLACE : tkh_pkg::ST_UP;
                    end
                    else if (in_value > root_reg)
                    begin
                        pos_next = '0;
                        rv_next  = right_ok;
                        state_next = left_ok ? tkh_pkg::ST_DOWN : tkh_pkg::ST_PLACE;
                    end
                    else
                    begin
                        state_next = tkh_pkg::ST_DONE;
                    end
                end
            end

            tkh_pkg::ST_UP:
            begin
                ram_wr_en = 1'b1;
                if (val_reg < ram_rd_data_a)
                begin
                    ram_wr_data = ram_rd_data_a;
                    pos_next    = cur_par;
                    state_next  = (cur_par == '0) ? tkh_pkg::ST_PLACE : tkh_pkg::ST_UP;
                end
                else
                begin
                    state_next = tkh_pkg::ST_DONE;
                end
            end

            tkh_pkg::ST_DOWN:
            begin
                ram_wr_en = 1'b1;
                if (val_reg <= pick_val)
                begin
                    state_next = tkh_pkg::ST_DONE;
                end
                else
                begin
                    ram_wr_data = pick_val;
                    pos_next    = pick_pos;
                    rv_next     = right_ok;
                    state_next  = left_ok ? tkh_pkg::ST_DOWN : tkh_pkg::ST_PLACE;
                end
            end

            tkh_pkg::ST_PLACE:
            begin
                ram_wr_en  = 1'b1;
                state_next = tkh_pkg::ST_DONE;
            end

            tkh_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = tkh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tkh_pkg::ST_IDLE;
            end
        endcase
    end

    // The root is shadowed so that the full-heap compare needs no read.
    assign root_next = (ram_wr_en && (ram_wr_addr == '0)) ? ram_wr_data : root_reg;

    assign res.smallest_kept = (fill_reg != '0) ? root_reg : '0;
    assign res.kept_count    = tkh_pkg::KEEP_W'(fill_reg);
    assign res.heap_full     = fill_reg >= lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkh_pkg::ST_IDLE;
            fill_reg  <= '0;
            keep_reg  <= tkh_pkg::KEEP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (keep_count_wr_en)
            begin
                keep_reg <= keep_count_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        rv_reg   <= rv_next;
        root_reg <= root_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/top_k_min_heap_keeper.sv
// ============================================================================
// top_k_min_heap_keeper
// Keeps the largest values offered so far in a binary min-heap held in RAM.
// ============================================================================
// Values enter on the s_axis channel, one per transaction. Each transaction
// yields exactly one result transaction on m_axis carrying the heap root
// (smallest value kept, zero while empty), the fill count and a full flag.
// keep_count_wr_en/keep_count_wr_data set how many values are kept; write
// it only while no transaction is in flight.
// A value that is dropped goes straight to a result; a sift walks the heap
// one heap level per cycle using the read ports of the heap RAM (both of
// them on the way down), and that walk sets the rate. A new value is
// accepted only once the sequencer is back in idle.
// Reset empties the heap and sets the limit to 64; the heap RAM itself is
// not cleared, since only filled entries are ever read.
// The result sits in an output register, so the next value is accepted
// while a result waits; if the receiver stalls longer, the sequencer holds
// its finished result and s_axis_tready stays low until the register frees.
// ============================================================================
`default_nettype none

module top_k_min_heap_keeper #(
    parameter int HEAP_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        keep_count_wr_en,
    input  wire logic [6:0]  keep_count_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [30:0] value, [31] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata    // [30:0] smallest_kept,
                                             // [37:31] kept_count,
                                             // [38] heap_full, [39] zero
);

    localparam int AW = $clog2(HEAP_DEPTH);

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [tkh_pkg::VALUE_W-1:0]   ram_wr_data;
    logic [AW-1:0]                 ram_rd_addr_a;
    logic [AW-1:0]                 ram_rd_addr_b;
    logic [tkh_pkg::VALUE_W-1:0]   ram_rd_data_a;
    logic [tkh_pkg::VALUE_W-1:0]   ram_rd_data_b;

    logic                          res_valid;
    logic                          res_ready;
    tkh_pkg::tkh_result_t          res;

    logic                          out_valid_reg;
    tkh_pkg::tkh_result_t          out_data_reg;

    tkh_ram #(
        .WIDTH (tkh_pkg::VALUE_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_a (ram_rd_data_a),
        .rd_data_b (ram_rd_data_b)
    );

    tkh_walker #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_walker (
        .clk                (clk),
        .rst_n              (rst_n),
        .keep_count_wr_en   (keep_count_wr_en),
        .keep_count_wr_data (keep_count_wr_data),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .in_value           (s_axis_tdata[tkh_pkg::VALUE_W-1:0]),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .res                (res),
        .ram_wr_en          (ram_wr_en),
        .ram_wr_addr        (ram_wr_addr),
        .ram_wr_data        (ram_wr_data),
        .ram_rd_addr_a      (ram_rd_addr_a),
        .ram_rd_addr_b      (ram_rd_addr_b),
        .ram_rd_data_a      (ram_rd_data_a),
        .ram_rd_data_b      (ram_rd_data_b)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/tkh_checker.sv
// ============================================================================
// tkh_checker
// Port-level checks for the top-K min-heap keeper, bound to the top level.
// ============================================================================
`default_nettype none

module tkh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        keep_count_wr_en,
    input wire logic [6:0]  keep_count_wr_data,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while stalled.");

    // Every result follows at least one stored value, so the count is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[37:31] != 7'd0)
    else $error("Result reports an empty heap.");

    // A new result cannot appear in the cycle right after a transaction is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("Result appeared too early.");

    // The pad bit of a result stays low.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[39])
    else $error("Padding bit set in result.");

endmodule

bind top_k_min_heap_keeper tkh_checker u_tkh_checker (.*);

`default_nettype wire

FILE: tb/tkh_stream_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// tkh_stream_checker
// Watches the keeper's channels, predicts each result and compares it.
// ============================================================================
// The checker keeps its own min-heap and limit register. It updates them on
// every limit write and on every value transaction, and queues the expected
// report. Each result transaction is compared field by field with the oldest
// queued report, and every mismatch is counted for the testbench top.
// ============================================================================

module tkh_stream_checker #(
    parameter int HEAP_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        keep_count_wr_en,
    input  wire logic [6:0]  keep_count_wr_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    output int               mismatch_count,
    output int               pending_reports,
    output int               reports_checked
);

    logic [tkh_pkg::VALUE_W-1:0] model_heap [HEAP_DEPTH];
    int                          model_fill;
    logic [tkh_pkg::KEEP_W-1:0]  model_keep;
    tkh_pkg::tkh_result_t        report_queue [$];

    function automatic int fill_limit();
        int lim;
        lim = int'(model_keep);
        if (lim == 0)
            lim = 1;
        if (lim > HEAP_DEPTH)
            lim = HEAP_DEPTH;
        return lim;
    endfunction

    function automatic tkh_pkg::tkh_result_t offer_value(
        input logic [tkh_pkg::VALUE_W-1:0] v
    );
        int                          pos;
        int                          parent;
        int                          left;
        int                          right;
        int                          pick;
        int                          n;
        logic [tkh_pkg::VALUE_W-1:0] tmp;
        tkh_pkg::tkh_result_t        r;
        if (model_fill < fill_limit())
        begin
            pos = model_fill;
            model_heap[pos] = v;
            model_fill++;
            while (pos > 0)
            begin
                parent = (pos - 1) / 2;
                if (model_heap[pos] >= model_heap[parent])
                    break;
                tmp = model_heap[pos];
                model_heap[pos] = model_heap[parent];
                model_heap[parent] = tmp;
                pos = parent;
            end
        end
        else if (v > model_heap[0])
        begin
            model_heap[0] = v;
            n = (model_fill > HEAP_DEPTH) ? HEAP_DEPTH : model_fill;
            pos = 0;
            forever
            begin
                left = 2 * pos + 1;
                right = left + 1;
                if (left >= n)
                    break;
                pick = left;
                if (right < n && model_heap[right] < model_heap[left])
                    pick = right;
                if (model_heap[pos] <= model_heap[pick])
                    break;
                tmp = model_heap[pos];
                model_heap[pos] = model_heap[pick];
                model_heap[pick] = tmp;
                pos = pick;
            end
        end
        r.smallest_kept = (model_fill > 0) ? model_heap[0] : '0;
        r.kept_count = tkh_pkg::KEEP_W'(model_fill);
        r.heap_full = (model_fill >= fill_limit());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tkh_pkg::tkh_result_t got;
        tkh_pkg::tkh_result_t want;
        if (!rst_n)
        begin
            model_fill = 0;
            model_keep = tkh_pkg::KEEP_RESET;
            report_queue.delete();
            mismatch_count = 0;
            pending_reports = 0;
            reports_checked = 0;
        end
        else
        begin
            if (keep_count_wr_en)
                model_keep = keep_count_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = tkh_pkg::tkh_result_t'(m_axis_tdata[38:0]);
                if (report_queue.size() == 0)
                begin
                    $error("Result transaction with no expectation waiting: %h",
                           m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = report_queue.pop_front();
                    reports_checked++;
                    if (got.smallest_kept !== want.smallest_kept)
                    begin
                        $error("smallest_kept: expected %0d, actual %0d",
                               want.smallest_kept, got.smallest_kept);
                        mismatch_count++;
                    end
                    if (got.kept_count !== want.kept_count)
                    begin
                        $error("kept_count: expected %0d, actual %0d",
                               want.kept_count, got.kept_count);
                        mismatch_count++;
                    end
                    if (got.heap_full !== want.heap_full)
                    begin
                        $error("heap_full: expected %0d, actual %0d",
                               want.heap_full, got.heap_full);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                report_queue.push_back(
                    offer_value(s_axis_tdata[tkh_pkg::VALUE_W-1:0]));
            pending_reports = report_queue.size();
        end
    end

endmodule

FILE: tb/tb_top_k_min_heap_keeper.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top_k_min_heap_keeper
// Stream testbench for the top-K min-heap keeper.
// ============================================================================
// A directed sequence covers the zero limit, a limit lowered below the fill
// level, values equal to the root and the extremes of the value range. Random
// phases then fill the heap under a series of limits, some above the heap size,
// with values drawn from the full range, from a narrow low range that repeats
// often, and from just below the maximum, while both channels stall at random
// in all phases but the last three. The checker module predicts and compares.
// ============================================================================

module tb_top_k_min_heap_keeper;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASE_ITEMS    = 117;

    logic        clk                = 1'b0;
    logic        rst_n              = 1'b0;
    logic        keep_count_wr_en   = 1'b0;
    logic [6:0]  keep_count_wr_data = '0;
    logic        s_axis_tvalid      = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata       = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready      = 1'b0;
    logic [39:0] m_axis_tdata;

    int mismatch_count;
    int pending_reports;
    int reports_checked;
    int src_idle_pct    = 15;
    int snk_idle_pct    = 80;
    int values_sent     = 0;
    int limit_writes    = 0;
    int quiet_cycles    = 0;
    int phase_keep [9]  = '{8, 24, 0, 48, 127, 2, 64, 1, 100};

    top_k_min_heap_keeper #(
        .HEAP_DEPTH(64)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .keep_count_wr_en  (keep_count_wr_en),
        .keep_count_wr_data(keep_count_wr_data),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata)
    );

    tkh_stream_checker #(
        .HEAP_DEPTH(64)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .keep_count_wr_en  (keep_count_wr_en),
        .keep_count_wr_data(keep_count_wr_data),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .mismatch_count    (mismatch_count),
        .pending_reports   (pending_reports),
        .reports_checked   (reports_checked)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transaction",
                     quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic offer(input logic [tkh_pkg::VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, v};
        do
            @(posedge clk);
        while (!s_axis_tready);
        values_sent++;
    endtask

    task automatic quiesce();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports != 0)
            @(negedge clk);
    endtask

    task automatic set_keep(input logic [tkh_pkg::KEEP_W-1:0] k);
        quiesce();
        keep_count_wr_en <= 1'b1;
        keep_count_wr_data <= k;
        @(negedge clk);
        keep_count_wr_en <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [tkh_pkg::VALUE_W-1:0] random_value();
        int sel;
        logic [31:0] raw;
        sel = $urandom_range(0, 9);
        raw = $urandom;
        if (sel < 4)
            return raw[tkh_pkg::VALUE_W-1:0];
        else if (sel < 7)
            return tkh_pkg::VALUE_W'($urandom_range(0, 255));
        else
            return 31'h7FFF_FF00 + tkh_pkg::VALUE_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        set_keep(7'd0);
        offer(31'd0);
        offer(31'h7FFF_FFFF);
        offer(31'h7FFF_FFFF);
        offer(31'd5);
        set_keep(7'd1);
        offer(31'h7FFF_FFFE);
        set_keep(7'd4);
        offer(31'd10);
        offer(31'd3);
        offer(31'd20);
        offer(31'd3);
        offer(31'd4);
        offer(31'h2AAA_AAAA);
        offer(31'h5555_5555);
        offer(31'd0);
        set_keep(7'd2);
        offer(31'd100);
        offer(31'd1);
        offer(31'h7FFF_FFFF);

        for (int phase = 0; phase < 9; phase++)
        begin
            set_keep(tkh_pkg::KEEP_W'(phase_keep[phase]));
            if (phase < 3)
            begin
                src_idle_pct = 15;
                snk_idle_pct = 80;
            end
            else if (phase < 6)
            begin
                src_idle_pct = 80;
                snk_idle_pct = 15;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                offer(random_value());
        end

        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Offered %0d values under %0d limit settings (zero, one, 64, 127 and more).",
                 values_sent, limit_writes);
        $display("Checked %0d results with %0d field mismatches.",
                 reports_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
